// ===== src/scp_pkg.sv =====
package scp_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int ROOT_BITS     = 34;
	localparam int QUO_BITS      = 32;

	localparam int MODE_EN  = 0;
	localparam int MODE_CAP = 1;
	localparam int MODE_IN  = 2;

	typedef struct packed {
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		logic [31:0] cx;
		logic [31:0] cy;
		logic [31:0] cz;
		logic [30:0] pr;
		logic [30:0] rad;
		logic [2:0]  mode;
	} item_t;

	function automatic logic [31:0] sat32(input logic signed [34:0] v);
		logic [31:0] r;
		if ((v[34:31] == 4'b0000) || (v[34:31] == 4'b1111)) begin
			r = v[31:0];
		end else if (v[34]) begin
			r = 32'h8000_0000;
		end else begin
			r = 32'h7fff_ffff;
		end
		return r;
	endfunction

endpackage

// ===== src/scp_center.sv =====
module scp_center #(
	parameter int FRAC_BITS = scp_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  scp_pkg::item_t      in_item,
	input  logic [2:0][31:0]    end_pt,
	output logic                out_vld,
	output scp_pkg::item_t      out_item,
	output logic [2:0][31:0]    ctr
);

	localparam longint EPS_SQ = (longint'(1) << (2 * FRAC_BITS)) / 1000000;
	localparam logic signed [67:0] EPS_SQ_W = 68'(EPS_SQ);

	logic [2:0][31:0] cin;
	assign cin[0] = in_item.cx;
	assign cin[1] = in_item.cy;
	assign cin[2] = in_item.cz;

	// differences
	logic                  vld_s1;
	scp_pkg::item_t        item_s1;
	logic signed [32:0]    sd_s1 [3];
	logic signed [32:0]    ad_s1 [3];
	logic [2:0][31:0]      pin;
	assign pin[0] = in_item.px;
	assign pin[1] = in_item.py;
	assign pin[2] = in_item.pz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_vld;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= in_item;
			for (int i = 0; i < 3; i++) begin
				sd_s1[i] <= $signed({end_pt[i][31], end_pt[i]}) - $signed({cin[i][31], cin[i]});
				ad_s1[i] <= $signed({pin[i][31], pin[i]}) - $signed({cin[i][31], cin[i]});
			end
		end
	end

	// products
	logic                  vld_s2;
	scp_pkg::item_t        item_s2;
	logic signed [32:0]    sd_s2 [3];
	logic signed [65:0]    ss_s2 [3];
	logic signed [65:0]    as_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			item_s2 <= item_s1;
			for (int i = 0; i < 3; i++) begin
				sd_s2[i] <= sd_s1[i];
				ss_s2[i] <= sd_s1[i] * sd_s1[i];
				as_s2[i] <= ad_s1[i] * sd_s1[i];
			end
		end
	end

	// sums, clamp decisions; division pipe entry at index 0
	logic signed [67:0] seg_c;
	logic signed [67:0] dot_c;
	logic               cap_c;
	logic               run_c;
	logic               full_c;

	assign seg_c  = 68'(ss_s2[0]) + 68'(ss_s2[1]) + 68'(ss_s2[2]);
	assign dot_c  = 68'(as_s2[0]) + 68'(as_s2[1]) + 68'(as_s2[2]);
	assign cap_c  = item_s2.mode[scp_pkg::MODE_CAP] && (seg_c > EPS_SQ_W);
	assign full_c = cap_c && (dot_c >= seg_c);
	assign run_c  = cap_c && (dot_c > 68'sd0) && (dot_c < seg_c);

	logic                  vld_sk  [FRAC_BITS+1];
	scp_pkg::item_t        item_sk [FRAC_BITS+1];
	logic signed [32:0]    sd_sk   [FRAC_BITS+1][3];
	logic [67:0]           rem_sk  [FRAC_BITS+1];
	logic [67:0]           seg_sk  [FRAC_BITS+1];
	logic [FRAC_BITS-1:0]  q_sk    [FRAC_BITS+1];
	logic                  run_sk  [FRAC_BITS+1];
	logic                  full_sk [FRAC_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_sk[0] <= 1'b0;
		else if (en) vld_sk[0] <= vld_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			item_sk[0] <= item_s2;
			for (int i = 0; i < 3; i++) sd_sk[0][i] <= sd_s2[i];
			rem_sk[0]  <= run_c ? dot_c : '0;
			seg_sk[0]  <= seg_c;
			q_sk[0]    <= '0;
			run_sk[0]  <= run_c;
			full_sk[0] <= full_c;
		end
	end

	// one quotient bit per stage
	for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
		logic [67:0] sh;
		logic        take;
		assign sh   = {rem_sk[k][66:0], 1'b0};
		assign take = run_sk[k] && (sh >= seg_sk[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_sk[k+1] <= 1'b0;
			else if (en) vld_sk[k+1] <= vld_sk[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				item_sk[k+1] <= item_sk[k];
				for (int i = 0; i < 3; i++) sd_sk[k+1][i] <= sd_sk[k][i];
				rem_sk[k+1]  <= take ? (sh - seg_sk[k]) : sh;
				seg_sk[k+1]  <= seg_sk[k];
				q_sk[k+1]    <= {q_sk[k][FRAC_BITS-2:0], take};
				run_sk[k+1]  <= run_sk[k];
				full_sk[k+1] <= full_sk[k];
			end
		end
	end

	// segment offset s * t
	logic signed [FRAC_BITS+1:0]  t_c;
	logic                         vld_sm;
	scp_pkg::item_t               item_sm;
	logic signed [FRAC_BITS+34:0] prod_sm [3];

	assign t_c = {1'b0, full_sk[FRAC_BITS], q_sk[FRAC_BITS]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_sm <= 1'b0;
		else if (en) vld_sm <= vld_sk[FRAC_BITS];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			item_sm <= item_sk[FRAC_BITS];
			for (int i = 0; i < 3; i++) prod_sm[i] <= sd_sk[FRAC_BITS][i] * t_c;
		end
	end

	// nearest point
	logic [2:0][31:0] cm;
	assign cm[0] = item_sm.cx;
	assign cm[1] = item_sm.cy;
	assign cm[2] = item_sm.cz;

	logic                 vld_sc;
	scp_pkg::item_t       item_sc;
	logic [2:0][31:0]     ctr_sc;
	logic signed [FRAC_BITS+34:0] sum_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_c[i] = (FRAC_BITS+35)'($signed(cm[i])) + (prod_sm[i] >>> FRAC_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_sc <= 1'b0;
		else if (en) vld_sc <= vld_sm;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			item_sc <= item_sm;
			for (int i = 0; i < 3; i++) ctr_sc[i] <= sum_c[i][31:0];
		end
	end

	assign out_vld  = vld_sc;
	assign out_item = item_sc;
	assign ctr      = ctr_sc;

endmodule

// ===== src/scp_dist.sv =====
module scp_dist (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  scp_pkg::item_t   in_item,
	input  logic [2:0][31:0] in_ctr,
	output logic             out_vld,
	output scp_pkg::item_t   out_item,
	output logic [2:0][31:0] out_ctr,
	output logic [2:0][32:0] out_dv,
	output logic [scp_pkg::ROOT_BITS-1:0] root
);

	localparam int RB = scp_pkg::ROOT_BITS;

	logic [2:0][31:0] pin;
	assign pin[0] = in_item.px;
	assign pin[1] = in_item.py;
	assign pin[2] = in_item.pz;

	logic             vld_s1;
	scp_pkg::item_t   item_s1;
	logic [2:0][31:0] ctr_s1;
	logic [2:0][32:0] dv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_vld;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= in_item;
			ctr_s1  <= in_ctr;
			for (int i = 0; i < 3; i++) begin
				dv_s1[i] <= {pin[i][31], pin[i]} - {in_ctr[i][31], in_ctr[i]};
			end
		end
	end

	// squares of the offset magnitudes
	logic [2:0][32:0] mag_c;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = dv_s1[i][32] ? (33'd0 - dv_s1[i]) : dv_s1[i];
		end
	end

	logic             vld_s2;
	scp_pkg::item_t   item_s2;
	logic [2:0][31:0] ctr_s2;
	logic [2:0][32:0] dv_s2;
	logic [63:0]      sq_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			item_s2 <= item_s1;
			ctr_s2  <= ctr_s1;
			dv_s2   <= dv_s1;
			for (int i = 0; i < 3; i++) sq_s2[i] <= mag_c[i][31:0] * mag_c[i][31:0];
		end
	end

	// square root, one root bit per stage, r^2 kept alongside
	logic             vld_sk  [RB+1];
	scp_pkg::item_t   item_sk [RB+1];
	logic [2:0][31:0] ctr_sk  [RB+1];
	logic [2:0][32:0] dv_sk   [RB+1];
	logic [65:0]      v_sk    [RB+1];
	logic [65:0]      rsq_sk  [RB+1];
	logic [RB-1:0]    root_sk [RB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_sk[0] <= 1'b0;
		else if (en) vld_sk[0] <= vld_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			item_sk[0] <= item_s2;
			ctr_sk[0]  <= ctr_s2;
			dv_sk[0]   <= dv_s2;
			v_sk[0]    <= 66'(sq_s2[0]) + 66'(sq_s2[1]) + 66'(sq_s2[2]);
			rsq_sk[0]  <= '0;
			root_sk[0] <= '0;
		end
	end

	for (genvar k = 0; k < RB; k++) begin : g_root
		localparam int B = RB - 1 - k;
		logic [69:0] cand;
		logic        take;
		assign cand = 70'(rsq_sk[k]) + (70'(root_sk[k]) << (B + 1)) + (70'(1) << (2 * B));
		assign take = cand <= 70'(v_sk[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_sk[k+1] <= 1'b0;
			else if (en) vld_sk[k+1] <= vld_sk[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				item_sk[k+1] <= item_sk[k];
				ctr_sk[k+1]  <= ctr_sk[k];
				dv_sk[k+1]   <= dv_sk[k];
				v_sk[k+1]    <= v_sk[k];
				rsq_sk[k+1]  <= take ? cand[65:0] : rsq_sk[k];
				root_sk[k+1] <= take ? (root_sk[k] | (RB'(1) << B)) : root_sk[k];
			end
		end
	end

	assign out_vld  = vld_sk[RB];
	assign out_item = item_sk[RB];
	assign out_ctr  = ctr_sk[RB];
	assign out_dv   = dv_sk[RB];
	assign root     = root_sk[RB];

endmodule

// ===== src/scp_proj.sv =====
module scp_proj #(
	parameter int FRAC_BITS = scp_pkg::FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  scp_pkg::item_t   in_item,
	input  logic [2:0][31:0] in_ctr,
	input  logic [2:0][32:0] in_dv,
	input  logic [scp_pkg::ROOT_BITS-1:0] root,
	output logic             out_vld,
	output logic [31:0]      res_x,
	output logic [31:0]      res_y,
	output logic [31:0]      res_z,
	output logic             res_moved
);

	localparam int RB = scp_pkg::ROOT_BITS;
	localparam int QB = scp_pkg::QUO_BITS;
	localparam longint EPS_D = (longint'(1) << FRAC_BITS) / 1000000;
	localparam logic [RB-1:0] EPS_D_W = RB'(EPS_D);

	// limit and decision
	logic          inside_c;
	logic [32:0]   lim_c;
	logic          hold_c;
	logic [2:0][31:0] mag_c;
	logic [2:0]    neg_c;

	assign inside_c = in_item.mode[scp_pkg::MODE_IN];
	assign lim_c = inside_c ? ((in_item.rad > in_item.pr) ? 33'(in_item.rad - in_item.pr) : 33'd0)
	                        : (33'(in_item.rad) + 33'(in_item.pr));
	assign hold_c = inside_c ? (RB'(root) <= RB'(lim_c)) : (RB'(root) >= RB'(lim_c));

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic [32:0] m;
			m        = in_dv[i][32] ? (33'd0 - in_dv[i]) : in_dv[i];
			mag_c[i] = m[31:0];
			neg_c[i] = in_dv[i][32];
		end
	end

	logic             vld_s1;
	scp_pkg::item_t   item_s1;
	logic [2:0][31:0] ctr_s1;
	logic [2:0][31:0] mag_s1;
	logic [2:0]       neg_s1;
	logic [32:0]      lim_s1;
	logic             act_s1;
	logic             zero_s1;
	logic [RB-1:0]    d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_vld;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= in_item;
			ctr_s1  <= in_ctr;
			mag_s1  <= mag_c;
			neg_s1  <= neg_c;
			lim_s1  <= lim_c;
			act_s1  <= in_item.mode[scp_pkg::MODE_EN] && !hold_c;
			zero_s1 <= root <= EPS_D_W;
			d_s1    <= root;
		end
	end

	// product into the division pipe, then one quotient bit per stage
	logic             vld_sk  [QB+1];
	scp_pkg::item_t   item_sk [QB+1];
	logic [2:0][31:0] ctr_sk  [QB+1];
	logic [2:0]       neg_sk  [QB+1];
	logic [32:0]      lim_sk  [QB+1];
	logic             act_sk  [QB+1];
	logic             zero_sk [QB+1];
	logic [RB-1:0]    d_sk    [QB+1];
	logic [RB:0]      rem_sk  [QB+1][3];
	logic [31:0]      lo_sk   [QB+1][3];
	logic [QB-1:0]    q_sk    [QB+1][3];
	logic [64:0]      prod_c  [3];

	always_comb begin
		for (int i = 0; i < 3; i++) prod_c[i] = mag_s1[i] * lim_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_sk[0] <= 1'b0;
		else if (en) vld_sk[0] <= vld_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			item_sk[0] <= item_s1;
			ctr_sk[0]  <= ctr_s1;
			neg_sk[0]  <= neg_s1;
			lim_sk[0]  <= lim_s1;
			act_sk[0]  <= act_s1;
			zero_sk[0] <= zero_s1;
			d_sk[0]    <= d_s1;
			for (int i = 0; i < 3; i++) begin
				rem_sk[0][i] <= (RB+1)'(prod_c[i][64:32]);
				lo_sk[0][i]  <= prod_c[i][31:0];
				q_sk[0][i]   <= '0;
			end
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		logic [RB:0] sh   [3];
		logic [2:0]  take;
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				sh[i]   = {rem_sk[k][i][RB-1:0], lo_sk[k][i][31]};
				take[i] = sh[i] >= {1'b0, d_sk[k]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_sk[k+1] <= 1'b0;
			else if (en) vld_sk[k+1] <= vld_sk[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				item_sk[k+1] <= item_sk[k];
				ctr_sk[k+1]  <= ctr_sk[k];
				neg_sk[k+1]  <= neg_sk[k];
				lim_sk[k+1]  <= lim_sk[k];
				act_sk[k+1]  <= act_sk[k];
				zero_sk[k+1] <= zero_sk[k];
				d_sk[k+1]    <= d_sk[k];
				for (int i = 0; i < 3; i++) begin
					rem_sk[k+1][i] <= take[i] ? (sh[i] - {1'b0, d_sk[k]}) : sh[i];
					lo_sk[k+1][i]  <= {lo_sk[k][i][30:0], 1'b0};
					q_sk[k+1][i]   <= {q_sk[k][i][QB-2:0], take[i]};
				end
			end
		end
	end

	// offsets, saturation and selection
	logic [2:0][31:0]   pt;
	logic [2:0][31:0]   proj_c;
	logic signed [34:0] ylim_c;

	assign pt[0] = item_sk[QB].px;
	assign pt[1] = item_sk[QB].py;
	assign pt[2] = item_sk[QB].pz;
	assign ylim_c = 35'($signed(ctr_sk[QB][1])) + $signed({2'b00, lim_sk[QB]});

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic signed [34:0] ofs;
			ofs = neg_sk[QB][i] ? -$signed({3'b000, q_sk[QB][i]})
			                    : $signed({3'b000, q_sk[QB][i]});
			proj_c[i] = scp_pkg::sat32(35'($signed(ctr_sk[QB][i])) + ofs);
		end
	end

	logic        vld_s35;
	logic [31:0] x_s35;
	logic [31:0] y_s35;
	logic [31:0] z_s35;
	logic        moved_s35;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s35 <= 1'b0;
		else if (en) vld_s35 <= vld_sk[QB];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			moved_s35 <= act_sk[QB];
			if (!act_sk[QB]) begin
				x_s35 <= pt[0];
				y_s35 <= pt[1];
				z_s35 <= pt[2];
			end else if (zero_sk[QB]) begin
				x_s35 <= pt[0];
				y_s35 <= scp_pkg::sat32(ylim_c);
				z_s35 <= pt[2];
			end else begin
				x_s35 <= proj_c[0];
				y_s35 <= proj_c[1];
				z_s35 <= proj_c[2];
			end
		end
	end

	assign out_vld   = vld_s35;
	assign res_x     = x_s35;
	assign res_y     = y_s35;
	assign res_z     = z_s35;
	assign res_moved = moved_s35;

endmodule

// ===== src/sphere_capsule_push_out.sv =====
// channel  | handshake                  | payload
// input    | in_valid / in_stall        | point, particle_radius, center, end, radius, mode
// output   | out_valid / out_stall      | out_x, out_y, out_z, moved
//
// one item enters per cycle while no result is held on the output
// the three bit-serial pipes set the depth: segment parameter (FRAC_BITS stages),
// square root (34 stages) and the three-lane projection divide (32 stages)
// arst_n clears all valid bits; payload registers are not reset
// a held result on the output freezes the whole pipe and raises in_stall
module sphere_capsule_push_out #(
	parameter int FRAC_BITS = scp_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] point_x,
	input  logic [31:0] point_y,
	input  logic [31:0] point_z,
	input  logic [30:0] particle_radius,
	input  logic [31:0] center_x,
	input  logic [31:0] center_y,
	input  logic [31:0] center_z,
	input  logic [31:0] end_x,
	input  logic [31:0] end_y,
	input  logic [31:0] end_z,
	input  logic [30:0] collider_radius,
	input  logic [2:0]  collider_mode,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_x,
	output logic [31:0] out_y,
	output logic [31:0] out_z,
	output logic        moved
);

	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	scp_pkg::item_t   item_in;
	logic [2:0][31:0] end_pt;

	assign item_in.px   = point_x;
	assign item_in.py   = point_y;
	assign item_in.pz   = point_z;
	assign item_in.cx   = center_x;
	assign item_in.cy   = center_y;
	assign item_in.cz   = center_z;
	assign item_in.pr   = particle_radius;
	assign item_in.rad  = collider_radius;
	assign item_in.mode = collider_mode;
	assign end_pt[0]    = end_x;
	assign end_pt[1]    = end_y;
	assign end_pt[2]    = end_z;

	logic             ctr_vld;
	scp_pkg::item_t   ctr_item;
	logic [2:0][31:0] ctr;

	scp_center #(.FRAC_BITS(FRAC_BITS)) u_center (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (in_valid),
		.in_item  (item_in),
		.end_pt   (end_pt),
		.out_vld  (ctr_vld),
		.out_item (ctr_item),
		.ctr      (ctr)
	);

	logic             dst_vld;
	scp_pkg::item_t   dst_item;
	logic [2:0][31:0] dst_ctr;
	logic [2:0][32:0] dst_dv;
	logic [scp_pkg::ROOT_BITS-1:0] dst_root;

	scp_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (ctr_vld),
		.in_item  (ctr_item),
		.in_ctr   (ctr),
		.out_vld  (dst_vld),
		.out_item (dst_item),
		.out_ctr  (dst_ctr),
		.out_dv   (dst_dv),
		.root     (dst_root)
	);

	scp_proj #(.FRAC_BITS(FRAC_BITS)) u_proj (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (dst_vld),
		.in_item   (dst_item),
		.in_ctr    (dst_ctr),
		.in_dv     (dst_dv),
		.root      (dst_root),
		.out_vld   (out_valid),
		.res_x     (out_x),
		.res_y     (out_y),
		.res_z     (out_z),
		.res_moved (moved)
	);

`ifndef SYNTHESIS
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled without a held item");

	a_pipe_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(ctr_vld) && $stable(dst_vld))
		else $error("pipe moved while output held");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_x) && $stable(out_y)
			&& $stable(out_z) && $stable(moved)))
		else $error("stalled output item changed");
`endif

endmodule

// ===== tb/sphere_capsule_push_out_tb.sv =====
module sphere_capsule_push_out_tb;

	localparam int FB = scp_pkg::FRAC_BITS_DEF;
	localparam logic signed [127:0] ONE_FX = 128'sd1 <<< FB;
	localparam logic signed [127:0] SEG_EPS = (128'sd1 <<< (2 * FB)) / 1000000;
	localparam logic signed [127:0] DIST_EPS = (128'sd1 <<< FB) / 1000000;
	localparam logic [2:0] EN = 3'(1 << scp_pkg::MODE_EN);
	localparam logic [2:0] CAP = 3'(1 << scp_pkg::MODE_CAP);
	localparam logic [2:0] INS = 3'(1 << scp_pkg::MODE_IN);
	localparam int N_RANDOM = 1035;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 150;

	typedef struct {
		logic [31:0] px, py, pz;
		logic [30:0] pr;
		logic [31:0] cx, cy, cz, ex, ey, ez;
		logic [30:0] rad;
		logic [2:0]  mode;
	} item_s;

	typedef struct {
		logic [31:0] x, y, z;
		logic        mv;
	} proj_s;

	typedef struct {
		item_s it;
		bit    known;
		proj_s want;
	} dir_row_s;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] point_x = '0, point_y = '0, point_z = '0;
	logic [30:0] particle_radius = '0;
	logic [31:0] center_x = '0, center_y = '0, center_z = '0;
	logic [31:0] end_x = '0, end_y = '0, end_z = '0;
	logic [30:0] collider_radius = '0;
	logic [2:0]  collider_mode = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] out_x, out_y, out_z;
	logic        moved;

	proj_s proj_q[$];
	int    mismatches = 0;
	int    idle_cycles = 0;
	bit    hold_req = 1'b0;

	sphere_capsule_push_out u_dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [31:0] clamp32(logic signed [127:0] v);
		if (v > 128'sh7fff_ffff) return 32'h7fff_ffff;
		if (v < -128'sh8000_0000) return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic proj_s push_out(item_s it);
		logic signed [127:0] p[3], c[3], e[3], s[3], ctr[3], dv[3];
		logic signed [127:0] seg, dot, d2, d, cand, lim, t, q;
		proj_s r;
		r = '{it.px, it.py, it.pz, 1'b0};
		p[0] = $signed(it.px); p[1] = $signed(it.py); p[2] = $signed(it.pz);
		c[0] = $signed(it.cx); c[1] = $signed(it.cy); c[2] = $signed(it.cz);
		e[0] = $signed(it.ex); e[1] = $signed(it.ey); e[2] = $signed(it.ez);
		if (!it.mode[scp_pkg::MODE_EN]) return r;
		for (int i = 0; i < 3; i++) ctr[i] = c[i];
		if (it.mode[scp_pkg::MODE_CAP]) begin
			seg = 0;
			dot = 0;
			for (int i = 0; i < 3; i++) begin
				s[i] = e[i] - c[i];
				seg += s[i] * s[i];
				dot += (p[i] - c[i]) * s[i];
			end
			if (seg > SEG_EPS) begin
				if (dot <= 0) t = 0;
				else if (dot >= seg) t = ONE_FX;
				else t = (dot <<< FB) / seg;
				for (int i = 0; i < 3; i++) ctr[i] = c[i] + ((s[i] * t) >>> FB);
			end
		end
		d2 = 0;
		for (int i = 0; i < 3; i++) begin
			dv[i] = p[i] - ctr[i];
			d2 += dv[i] * dv[i];
		end
		d = 0;
		for (int b = 35; b >= 0; b--) begin
			cand = d | (128'sd1 <<< b);
			if (cand * cand <= d2) d = cand;
		end
		if (it.mode[scp_pkg::MODE_IN])
			lim = it.rad > it.pr ? $signed({97'd0, it.rad - it.pr}) : 0;
		else lim = $signed({97'd0, it.rad}) + $signed({97'd0, it.pr});
		if ((!it.mode[scp_pkg::MODE_IN] && d >= lim) || (it.mode[scp_pkg::MODE_IN] && d <= lim))
			return r;
		r.mv = 1'b1;
		if (d <= DIST_EPS) begin
			r.y = clamp32(ctr[1] + lim);
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			q = ((dv[i] < 0 ? -dv[i] : dv[i]) * lim) / d;
			if (i == 0) r.x = clamp32(ctr[i] + (dv[i] < 0 ? -q : q));
			if (i == 1) r.y = clamp32(ctr[i] + (dv[i] < 0 ? -q : q));
			if (i == 2) r.z = clamp32(ctr[i] + (dv[i] < 0 ? -q : q));
		end
		return r;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($urandom_range(0, 32'h8000_0000)) - 32'h8000_0000;
			2: return 32'h7fff_ffff - $urandom_range(0, 32'h3_0000);
			default: return 32'h8000_0000 + $urandom_range(0, 32'h3_0000);
		endcase
	endfunction

	function automatic logic [31:0] near(logic [31:0] base, int unsigned span);
		if ($urandom_range(0, 9) == 0) return $urandom;
		return base + $urandom_range(0, 2 * span) - span;
	endfunction

	function automatic logic [30:0] rand_radius();
		if ($urandom_range(0, 4) == 0) return 31'($urandom);
		return 31'($urandom_range(0, 32'h4_0000));
	endfunction

	function automatic item_s rand_item();
		item_s it;
		int unsigned span;
		span = $urandom_range(0, 1) ? 32'h8_0000 : 32'h400;
		it.cx = rand_coord(); it.cy = rand_coord(); it.cz = rand_coord();
		it.px = near(it.cx, span); it.py = near(it.cy, span); it.pz = near(it.cz, span);
		case ($urandom_range(0, 3))
			0: begin it.ex = it.cx; it.ey = it.cy; it.ez = it.cz + $urandom_range(0, 1); end
			1: begin it.ex = $urandom; it.ey = $urandom; it.ez = $urandom; end
			default: begin
				it.ex = near(it.cx, span); it.ey = near(it.cy, span); it.ez = near(it.cz, span);
			end
		endcase
		it.rad = rand_radius();
		it.pr = rand_radius();
		it.mode = 3'($urandom);
		if ($urandom_range(0, 7) != 0) it.mode |= EN;
		return it;
	endfunction

	task automatic send(item_s it, bit known, proj_s want);
		point_x <= it.px; point_y <= it.py; point_z <= it.pz;
		particle_radius <= it.pr;
		center_x <= it.cx; center_y <= it.cy; center_z <= it.cz;
		end_x <= it.ex; end_y <= it.ey; end_z <= it.ez;
		collider_radius <= it.rad;
		collider_mode <= it.mode;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		proj_q.insert(proj_q.size(), known ? want : push_out(it));
	endtask

	dir_row_s dir_tab[15] = '{
		'{'{32'h8000_0000, 32'h7fff_ffff, 32'h0, 31'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
			32'hffff_ffff, 32'h0, 32'h0, 32'h0, 31'h7fff_ffff, 3'b000},
			1, '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 1'b0}},
		'{'{32'h1, 32'h2, 32'h3, 31'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 31'h0, CAP | INS},
			1, '{32'h1, 32'h2, 32'h3, 1'b0}},
		'{'{32'h0, 32'h0, 32'h0, 31'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 31'h1_0000, EN},
			1, '{32'h0, 32'h1_0000, 32'h0, 1'b1}},
		'{'{32'h0, 32'h7fff_0000, 32'h0, 31'h7fff_ffff, 32'h0, 32'h7fff_0000, 32'h0, 32'h0, 32'h0,
			32'h0, 31'h7fff_ffff, EN}, 1, '{32'h0, 32'h7fff_ffff, 32'h0, 1'b1}},
		'{'{32'h5, 32'h5, 32'h5, 31'h0, 32'h5, 32'h5, 32'h5, 32'h0, 32'h0, 32'h0, 31'h1_0000,
			EN | INS}, 1, '{32'h5, 32'h5, 32'h5, 1'b0}},
		'{'{32'h1_0000, 32'h0, 32'h0, 31'h5, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 31'h1,
			EN | INS}, 1, '{32'h0, 32'h0, 32'h0, 1'b1}},
		'{'{32'h10_0000, 32'h0, 32'h0, 31'h1_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
			31'h1_0000, EN}, 1, '{32'h10_0000, 32'h0, 32'h0, 1'b0}},
		'{'{32'h8000, 32'h3000, 32'hffff_f000, 31'h8000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
			31'h3_0000, EN}, 0, '{default: '0}},
		'{'{32'hfffe_0000, 32'h8000, 32'h0, 31'h0, 32'h0, 32'h0, 32'h0, 32'h10_0000, 32'h0, 32'h0,
			31'h2_0000, EN | CAP}, 0, '{default: '0}},
		'{'{32'h13_0000, 32'h4000, 32'h0, 31'h0, 32'h0, 32'h0, 32'h0, 32'h10_0000, 32'h0, 32'h0,
			31'h2_0000, EN | CAP}, 0, '{default: '0}},
		'{'{32'h8_0000, 32'hffff_a000, 32'h2000, 31'h1000, 32'h0, 32'h0, 32'h0, 32'h10_0000, 32'h0,
			32'h0, 31'h2_0000, EN | CAP}, 0, '{default: '0}},
		'{'{32'h4000, 32'h4000, 32'h0, 31'h0, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 31'h2_0000,
			EN | CAP}, 0, '{default: '0}},
		'{'{32'h5_0000, 32'h9_0000, 32'h0, 31'h4000, 32'h0, 32'h0, 32'h0, 32'h10_0000, 32'h0,
			32'h0, 31'h2_0000, EN | CAP | INS}, 0, '{default: '0}},
		'{'{32'h7fff_8000, 32'h0, 32'h0, 31'h0, 32'h7fff_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
			31'h7fff_ffff, EN}, 0, '{default: '0}},
		'{'{32'h0, 32'h100, 32'hffff_ff00, 31'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h1_0000, EN | CAP}, 0, '{default: '0}}
	};

	always @(posedge clk) begin
		proj_s want;
		if (out_valid && !out_stall) begin
			if (proj_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected item %h %h %h %b", out_x, out_y, out_z, moved);
			end else begin
				want = proj_q.pop_front();
				if (out_x !== want.x || out_y !== want.y || out_z !== want.z || moved !== want.mv) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp %h %h %h %b got %h %h %h %b", want.x, want.y, want.z,
							want.mv, out_x, out_y, out_z, moved);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int unsigned pct, n;
		forever begin
			n = $urandom_range(5, 60);
			case ($urandom_range(0, 2))
				0: pct = 0;
				1: pct = 30;
				default: pct = 75;
			endcase
			repeat (n) begin
				@(posedge clk);
				if (hold_req) begin
					out_stall <= 1'b1;
					repeat (HOLD_CYCLES) @(posedge clk);
					hold_req = 1'b0;
				end else begin
					out_stall <= ($urandom_range(0, 99) < pct);
				end
			end
		end
	end

	initial begin
		int burst;
		burst = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[i]) send(dir_tab[i].it, dir_tab[i].known, dir_tab[i].want);
		for (int k = 0; k < N_RANDOM; k++) begin
			if (k == 300) hold_req = 1'b1;
			if (k == 650) begin
				in_valid <= 1'b0;
				while (proj_q.size() != 0) @(posedge clk);
			end else if (burst <= 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(0, 1) ? $urandom_range(1, 20) : 0) @(posedge clk);
				burst = $urandom_range(1, 40);
			end
			burst--;
			send(rand_item(), 1'b0, '{default: '0});
		end
		in_valid <= 1'b0;
		while (proj_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/scp_pkg.sv
src/scp_center.sv
src/scp_dist.sv
src/scp_proj.sv
src/sphere_capsule_push_out.sv
tb/sphere_capsule_push_out_tb.sv
